[design/file_magic_classifier_core_defines.svh]
// assertion macros shared by the checker files
// every macro samples on clk and is held off while arst_n is low
`ifndef FILE_MAGIC_CLASSIFIER_CORE_DEFINES_SVH
`define FILE_MAGIC_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define FMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fmc_pkg.sv]
// ----------------------------------------------------------------------------
// fmc_pkg
// types, codes and magic tables of the file signature classifier
// ----------------------------------------------------------------------------
package fmc_pkg;

	localparam int NUM_MAGICS    = 11;
	localparam int MAX_MAGIC_LEN = 15;
	localparam int POS_SATURATE  = 16;

	// item kind on the head channel
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} item_kind_t;

	// result classes
	typedef enum logic [3:0] {
		CLS_TIFF    = 4'd0,
		CLS_BIGTIFF = 4'd1,
		CLS_ZIP     = 4'd2,
		CLS_SQLITE  = 4'd3,
		CLS_HDF5    = 4'd4,
		CLS_HDF4    = 4'd5,
		CLS_NETCDF  = 4'd6,
		CLS_JSON    = 4'd7,
		CLS_XML     = 4'd8,
		CLS_TEXT    = 4'd9,
		CLS_UNKNOWN = 4'd10
	} sig_class_t;

	// class of the first byte that is not whitespace
	typedef enum logic [1:0] {
		FNS_OTHER   = 2'd0,
		FNS_BRACKET = 2'd1,
		FNS_ANGLE   = 2'd2
	} fns_kind_t;

	// special byte values
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_LT       = 8'h3C;

	// per-head tracking state
	typedef struct packed {
		logic [4:0]            byte_position;
		logic [NUM_MAGICS-1:0] pattern_alive;
		logic                  all_printable;
		logic                  saw_any_byte;
		logic                  saw_nonspace;
		fns_kind_t             first_nonspace_kind;
	} head_state_t;

	localparam head_state_t STATE_RESET = '{
		byte_position:       5'd0,
		pattern_alive:       {NUM_MAGICS{1'b1}},
		all_printable:       1'b1,
		saw_any_byte:        1'b0,
		saw_nonspace:        1'b0,
		first_nonspace_kind: FNS_OTHER
	};

	// magic lengths, in priority order
	localparam logic [4:0] MAGIC_LEN [NUM_MAGICS] = '{
		5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd15, 5'd8, 5'd4, 5'd4, 5'd4
	};

	localparam sig_class_t MAGIC_CLASS [NUM_MAGICS] = '{
		CLS_TIFF, CLS_TIFF, CLS_BIGTIFF, CLS_BIGTIFF, CLS_ZIP, CLS_ZIP,
		CLS_SQLITE, CLS_HDF5, CLS_HDF4, CLS_NETCDF, CLS_NETCDF
	};

	// magic bytes, zero padded past each length
	localparam logic [7:0] MAGIC_BYTES [NUM_MAGICS][MAX_MAGIC_LEN] = '{
		'{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h49, 8'h49, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4D, 8'h4D, 8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h53, 8'h51, 8'h4C, 8'h69, 8'h74, 8'h65, 8'h20, 8'h66,
		  8'h6F, 8'h72, 8'h6D, 8'h61, 8'h74, 8'h20, 8'h33},
		'{8'h89, 8'h48, 8'h44, 8'h46, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h0E, 8'h03, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h43, 8'h44, 8'h46, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h43, 8'h44, 8'h46, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

endpackage

[design/fmc_head_if.sv]
// ----------------------------------------------------------------------------
// fmc_head_if
// head channel: one file byte or an end marker per beat
// ----------------------------------------------------------------------------
interface fmc_head_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink (input valid, input kind, input byte_value, output ready);
endinterface

[design/fmc_verdict_if.sv]
// ----------------------------------------------------------------------------
// fmc_verdict_if
// verdict channel: one signature class per beat
// ----------------------------------------------------------------------------
interface fmc_verdict_if;
	logic       valid;
	logic       ready;
	logic [3:0] signature_class;

	modport source (output valid, output signature_class, input ready);
	modport sink (input valid, input signature_class, output ready);
endinterface

[design/file_magic_classifier_core.sv]
// ----------------------------------------------------------------------------
// file_magic_classifier_core
// classifies a file from its head bytes by magic prefix, then by text shape
// ----------------------------------------------------------------------------
// usage:
//   head    : one beat per file byte (kind 0), then one end beat (kind 1)
//   verdict : one beat per end beat, carrying the signature class
//   a byte beat produces no verdict; it only updates the tracking flags
// timing:
//   every beat is latched into an input stage, then updated against the
//   tracking state in one pass; the verdict of an end beat is registered
//   in the verdict register when the beat leaves the input stage
//   throughput is one beat per cycle, unless an end beat waits on a held verdict
// reset:
//   arst_n clears the input stage, the verdict register and the tracking
//   state; after an end beat the tracking state restarts for a new head
// stall:
//   while verdict is held, byte beats keep flowing; an end beat waits in
//   the input stage until the verdict register frees, and head.ready drops
// ----------------------------------------------------------------------------
module file_magic_classifier_core (
	input  logic          clk,
	input  logic          arst_n,
	fmc_head_if.sink      head,
	fmc_verdict_if.source verdict
);

	logic                     valid_s1;
	logic                     kind_s1;
	logic [7:0]               byte_s1;
	logic                     go_s1;
	logic                     out_valid_q;
	fmc_pkg::sig_class_t      out_class_q;
	fmc_pkg::head_state_t     state_q;
	fmc_pkg::head_state_t     state_d;
	fmc_pkg::sig_class_t      end_class;
	logic                     is_space;
	logic                     is_printable;

	// an end beat needs the verdict register free, a byte beat never waits
	assign go_s1 = valid_s1 &&
		(kind_s1 == fmc_pkg::KIND_BYTE || !out_valid_q || verdict.ready);
	assign head.ready = !valid_s1 || go_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (head.ready) begin
			valid_s1 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (head.valid && head.ready) begin
			kind_s1 <= head.kind;
			byte_s1 <= head.byte_value;
		end
	end

	// byte classification
	assign is_space = byte_s1 == fmc_pkg::CH_SPACE || byte_s1 == fmc_pkg::CH_TAB ||
		byte_s1 == fmc_pkg::CH_LF || byte_s1 == fmc_pkg::CH_CR;
	assign is_printable = byte_s1 == fmc_pkg::CH_TAB || byte_s1 == fmc_pkg::CH_LF ||
		byte_s1 == fmc_pkg::CH_CR ||
		(byte_s1 >= fmc_pkg::CH_SPACE && byte_s1 != fmc_pkg::CH_DEL);

	// verdict from the current state, first live magic wins
	always_comb begin
		logic hit;
		hit = 1'b0;
		end_class = fmc_pkg::CLS_UNKNOWN;
		for (int i = fmc_pkg::NUM_MAGICS - 1; i >= 0; i--) begin
			if (state_q.pattern_alive[i] &&
				state_q.byte_position >= fmc_pkg::MAGIC_LEN[i]) begin
				hit = 1'b1;
				end_class = fmc_pkg::MAGIC_CLASS[i];
			end
		end
		if (!state_q.saw_any_byte) begin
			end_class = fmc_pkg::CLS_UNKNOWN;
		end else if (!hit) begin
			if (!state_q.all_printable) begin
				end_class = fmc_pkg::CLS_UNKNOWN;
			end else if (state_q.saw_nonspace &&
				state_q.first_nonspace_kind == fmc_pkg::FNS_BRACKET) begin
				end_class = fmc_pkg::CLS_JSON;
			end else if (state_q.saw_nonspace &&
				state_q.first_nonspace_kind == fmc_pkg::FNS_ANGLE) begin
				end_class = fmc_pkg::CLS_XML;
			end else begin
				end_class = fmc_pkg::CLS_TEXT;
			end
		end
	end

	// tracking state update for the beat in the input stage
	always_comb begin
		logic [3:0] idx;
		idx = state_q.byte_position[3:0];
		state_d = state_q;
		if (go_s1) begin
			if (kind_s1 == fmc_pkg::KIND_END) begin
				state_d = fmc_pkg::STATE_RESET;
			end else begin
				for (int i = 0; i < fmc_pkg::NUM_MAGICS; i++) begin
					if (state_q.byte_position < 5'(fmc_pkg::MAX_MAGIC_LEN) &&
						state_q.byte_position < fmc_pkg::MAGIC_LEN[i] &&
						fmc_pkg::MAGIC_BYTES[i][idx] != byte_s1) begin
						state_d.pattern_alive[i] = 1'b0;
					end
				end
				if (state_q.byte_position < 5'(fmc_pkg::POS_SATURATE)) begin
					state_d.byte_position = state_q.byte_position + 5'd1;
				end
				if (!is_printable) begin
					state_d.all_printable = 1'b0;
				end
				state_d.saw_any_byte = 1'b1;
				if (!state_q.saw_nonspace && !is_space) begin
					state_d.saw_nonspace = 1'b1;
					if (byte_s1 == fmc_pkg::CH_LBRACE || byte_s1 == fmc_pkg::CH_LBRACKET) begin
						state_d.first_nonspace_kind = fmc_pkg::FNS_BRACKET;
					end else if (byte_s1 == fmc_pkg::CH_LT) begin
						state_d.first_nonspace_kind = fmc_pkg::FNS_ANGLE;
					end else begin
						state_d.first_nonspace_kind = fmc_pkg::FNS_OTHER;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmc_pkg::STATE_RESET;
		end else begin
			state_q <= state_d;
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && kind_s1 == fmc_pkg::KIND_END) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && kind_s1 == fmc_pkg::KIND_END) begin
			out_class_q <= end_class;
		end
	end

	assign verdict.valid           = out_valid_q;
	assign verdict.signature_class = out_class_q;

endmodule

[design/fmc_checker.sv]
// ----------------------------------------------------------------------------
// fmc_checker
// port-level checks of the file signature classifier
// ----------------------------------------------------------------------------
`include "file_magic_classifier_core_defines.svh"

module fmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       head_valid,
	input logic       head_ready,
	input logic       verdict_valid,
	input logic       verdict_ready,
	input logic [3:0] verdict_class
);

	// a held verdict beat keeps its value
	`FMC_ASSERT_NEXT(a_verdict_hold, verdict_valid && !verdict_ready, verdict_valid && $stable(verdict_class), "verdict beat changed while stalled")

	// only the eleven defined classes ever leave the block
	`FMC_ASSERT_NOW(a_class_range, verdict_valid, verdict_class <= 4'(fmc_pkg::CLS_UNKNOWN), "verdict class out of range")

	// head backpressure only comes from a stalled verdict
	`FMC_ASSERT_NOW(a_ready_cause, !head_ready, verdict_valid && !verdict_ready, "head stalled without a stalled verdict")

	// a head beat offered while ready low stays offered is the source's job; here
	// ready low in one cycle with the verdict taken must free the head next cycle
	`FMC_ASSERT_NEXT(a_ready_frees, !head_ready && verdict_ready, head_ready, "head not freed after verdict beat")

endmodule

bind file_magic_classifier_core fmc_checker u_fmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.head_valid    (head.valid),
	.head_ready    (head.ready),
	.verdict_valid (verdict.valid),
	.verdict_ready (verdict.ready),
	.verdict_class (verdict.signature_class)
);

[tb/fmc_verdict_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fmc_verdict_checker
// watches the head and verdict channels, tracks each head byte by byte and
// compares every verdict beat against the class predicted for its head
// ----------------------------------------------------------------------------
module fmc_verdict_checker (
	input  logic   clk,
	input  logic   arst_n,
	fmc_head_if    head,
	fmc_verdict_if verdict,
	output int     mismatch_count,
	output int     results_waiting
);

	localparam int SHOW_LIMIT = 10;

	// predicted tracking state of the current head
	logic [4:0]                     seen_count;
	logic [fmc_pkg::NUM_MAGICS-1:0] magic_live;
	logic                           text_only;
	logic                           got_byte;
	logic                           got_nonspace;
	fmc_pkg::fns_kind_t             lead_kind;

	// classes predicted for heads whose verdict has not come yet
	fmc_pkg::sig_class_t class_q[$];
	int                  shown_count;

	function automatic void restart_head();
		seen_count   = '0;
		magic_live   = '1;
		text_only    = 1'b1;
		got_byte     = 1'b0;
		got_nonspace = 1'b0;
		lead_kind    = fmc_pkg::FNS_OTHER;
	endfunction

	// fold one head byte into the tracking state
	function automatic void absorb_byte(input logic [7:0] b);
		if (seen_count < fmc_pkg::MAX_MAGIC_LEN) begin
			for (int i = 0; i < fmc_pkg::NUM_MAGICS; i++) begin
				if (seen_count < fmc_pkg::MAGIC_LEN[i] &&
					fmc_pkg::MAGIC_BYTES[i][seen_count] != b)
					magic_live[i] = 1'b0;
			end
		end
		if (seen_count < fmc_pkg::POS_SATURATE)
			seen_count = seen_count + 5'd1;
		if (!(b == fmc_pkg::CH_TAB || b == fmc_pkg::CH_LF || b == fmc_pkg::CH_CR) &&
			(b < fmc_pkg::CH_SPACE || b == fmc_pkg::CH_DEL))
			text_only = 1'b0;
		got_byte = 1'b1;
		if (!got_nonspace && !(b == fmc_pkg::CH_SPACE || b == fmc_pkg::CH_TAB ||
			b == fmc_pkg::CH_LF || b == fmc_pkg::CH_CR)) begin
			got_nonspace = 1'b1;
			if (b == fmc_pkg::CH_LBRACE || b == fmc_pkg::CH_LBRACKET)
				lead_kind = fmc_pkg::FNS_BRACKET;
			else if (b == fmc_pkg::CH_LT)
				lead_kind = fmc_pkg::FNS_ANGLE;
			else
				lead_kind = fmc_pkg::FNS_OTHER;
		end
	endfunction

	// class of the head so far: magics by priority, then text shape
	function automatic fmc_pkg::sig_class_t head_class();
		if (!got_byte)
			return fmc_pkg::CLS_UNKNOWN;
		for (int i = 0; i < fmc_pkg::NUM_MAGICS; i++) begin
			if (magic_live[i] && seen_count >= fmc_pkg::MAGIC_LEN[i])
				return fmc_pkg::MAGIC_CLASS[i];
		end
		if (!text_only)
			return fmc_pkg::CLS_UNKNOWN;
		if (got_nonspace && lead_kind == fmc_pkg::FNS_BRACKET)
			return fmc_pkg::CLS_JSON;
		if (got_nonspace && lead_kind == fmc_pkg::FNS_ANGLE)
			return fmc_pkg::CLS_XML;
		return fmc_pkg::CLS_TEXT;
	endfunction

	// compare verdict beats, then predict from head beats
	always @(posedge clk or negedge arst_n) begin
		fmc_pkg::sig_class_t want;
		if (!arst_n) begin
			restart_head();
			class_q.delete();
			mismatch_count = 0;
			shown_count = 0;
			results_waiting <= 0;
		end else begin
			if (verdict.valid && verdict.ready) begin
				if (class_q.size() == 0) begin
					mismatch_count++;
					if (shown_count < SHOW_LIMIT) begin
						shown_count++;
						$display("%0t: verdict beat %0d with no head pending", $realtime,
							verdict.signature_class);
					end
				end else begin
					want = class_q.pop_front();
					if (verdict.signature_class !== want) begin
						mismatch_count++;
						if (shown_count < SHOW_LIMIT) begin
							shown_count++;
							$display("%0t: signature_class expected %0d (%s) got %0d",
								$realtime, want, want.name(), verdict.signature_class);
						end
					end
				end
			end
			if (head.valid && head.ready) begin
				if (head.kind == fmc_pkg::KIND_END) begin
					class_q.push_back(head_class());
					restart_head();
				end else begin
					absorb_byte(head.byte_value);
				end
			end
			results_waiting <= class_q.size();
		end
	end

endmodule

[tb/file_magic_classifier_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// file_magic_classifier_core_tb
// feeds directed and random file heads (magics, damaged magics, text, json,
// xml, binary, empty and long heads) with random gaps on both channels
// ----------------------------------------------------------------------------
module file_magic_classifier_core_tb;

	localparam int ITEM_TARGET   = 1000;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n;

	fmc_head_if    head_ch ();
	fmc_verdict_if verdict_ch ();

	int         mismatch_count;
	int         results_waiting;
	int         items_sent;
	int         idle_cycles;
	bit         steady_feed;
	logic [7:0] head_buf[$];

	always #6 clk = ~clk;

	file_magic_classifier_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head_ch),
		.verdict (verdict_ch)
	);

	fmc_verdict_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head_ch),
		.verdict         (verdict_ch),
		.mismatch_count  (mismatch_count),
		.results_waiting (results_waiting)
	);

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(0, 3))
			0: return fmc_pkg::CH_SPACE;
			1: return fmc_pkg::CH_TAB;
			2: return fmc_pkg::CH_LF;
			default: return fmc_pkg::CH_CR;
		endcase
	endfunction

	// printable byte, high half included
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return space_byte();
		if (r < 7)
			return 8'($urandom_range(32, 126));
		return 8'($urandom_range(128, 255));
	endfunction

	function automatic int tail_length();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(13, 30);
		return $urandom_range(0, 8);
	endfunction

	// one beat on the head channel, after a random gap unless steady_feed is set
	task automatic send_beat(input fmc_pkg::item_kind_t k, input logic [7:0] b);
		int gap;
		gap = steady_feed ? 0 : pick_gap();
		if (gap != 0) begin
			head_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		head_ch.valid      <= 1'b1;
		head_ch.kind       <= k;
		head_ch.byte_value <= b;
		do @(posedge clk); while (!head_ch.ready);
		items_sent++;
	endtask

	task automatic send_head();
		foreach (head_buf[i])
			send_beat(fmc_pkg::KIND_BYTE, head_buf[i]);
		send_beat(fmc_pkg::KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// hold the sender until every verdict has come back
	task automatic drain_verdicts();
		head_ch.valid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
	endtask

	task automatic append_magic(input int idx, input int len);
		for (int i = 0; i < len; i++)
			head_buf.push_back(fmc_pkg::MAGIC_BYTES[idx][i]);
	endtask

	// magic head: sometimes cut short or damaged; a full-length magic gets a tail
	task automatic build_magic_head();
		int idx;
		int len;
		int n;
		idx = $urandom_range(0, fmc_pkg::NUM_MAGICS - 1);
		len = fmc_pkg::MAGIC_LEN[idx];
		if ($urandom_range(0, 6) == 0)
			len = $urandom_range(1, len - 1);
		append_magic(idx, len);
		if ($urandom_range(0, 4) == 0)
			head_buf[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
		if (len == fmc_pkg::MAGIC_LEN[idx]) begin
			n = tail_length();
			if ($urandom_range(0, 1) == 0) begin
				repeat (n) head_buf.push_back(text_byte());
			end else begin
				repeat (n) head_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// text head: leading whitespace, a first character, printable body
	task automatic build_text_head();
		int n;
		repeat ($urandom_range(0, 3)) head_buf.push_back(space_byte());
		case ($urandom_range(0, 4))
			0: head_buf.push_back(fmc_pkg::CH_LBRACE);
			1: head_buf.push_back(fmc_pkg::CH_LBRACKET);
			2: head_buf.push_back(fmc_pkg::CH_LT);
			3: head_buf.push_back(text_byte());
			default: head_buf.push_back(space_byte());
		endcase
		n = tail_length();
		repeat (n) head_buf.push_back(text_byte());
		// an occasional control byte spoils the text, unless it is a tab, lf or cr
		if ($urandom_range(0, 5) == 0) begin
			if ($urandom_range(0, 3) == 0)
				head_buf.insert($urandom_range(0, head_buf.size()), fmc_pkg::CH_DEL);
			else
				head_buf.insert($urandom_range(0, head_buf.size()),
					8'($urandom_range(0, 31)));
		end
	endtask

	// receiver: random stalls, with calm stretches of steady ready
	initial begin
		int stall_left;
		int calm_left;
		bit calm;
		verdict_ch.ready = 1'b0;
		stall_left = 0;
		calm_left = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(40, 300);
			end else begin
				calm_left--;
			end
			if (stall_left != 0) begin
				stall_left--;
				verdict_ch.ready <= 1'b0;
			end else begin
				verdict_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((head_ch.valid && head_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		head_ch.valid = 1'b0;
		head_ch.kind = fmc_pkg::KIND_BYTE;
		head_ch.byte_value = 8'h00;
		steady_feed = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty head
		head_buf.delete();
		send_head();
		// tiff magic, then a new head after the end beat
		head_buf.delete();
		append_magic(0, 4);
		send_head();
		// binary extremes, no magic
		head_buf = '{8'h00, 8'hFF};
		send_head();
		// whitespace only
		head_buf = '{fmc_pkg::CH_SPACE, fmc_pkg::CH_TAB, fmc_pkg::CH_CR, fmc_pkg::CH_LF};
		send_head();
		// json and xml leads
		head_buf = '{fmc_pkg::CH_SPACE, fmc_pkg::CH_LBRACE};
		send_head();
		head_buf = '{fmc_pkg::CH_LT};
		send_head();
		// delete is not printable
		head_buf = '{fmc_pkg::CH_DEL};
		send_head();
		// high half is printable text
		head_buf = '{8'h61, 8'hFF};
		send_head();
		drain_verdicts();

		// random heads
		while (items_sent < ITEM_TARGET) begin
			steady_feed = ($urandom_range(0, 4) == 0);
			head_buf.delete();
			case ($urandom_range(0, 19))
				0: ;
				1, 2: repeat ($urandom_range(1, 12))
					head_buf.push_back(8'($urandom_range(0, 255)));
				3, 4, 5, 6, 7, 8, 9: build_text_head();
				default: build_magic_head();
			endcase
			send_head();
			if ($urandom_range(0, 24) == 0)
				drain_verdicts();
		end
		steady_feed = 1'b0;
		drain_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && results_waiting == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
